// ----- design/amwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amwd_pkg
// types and constants shared by the adc module word decoder
// ----------------------------------------------------------------------------
package amwd_pkg;

    // readout word type codes, bits 30..27 of a type word
    localparam logic [3:0] TYPE_BLOCK_HDR   = 4'd0;
    localparam logic [3:0] TYPE_BLOCK_TRL   = 4'd1;
    localparam logic [3:0] TYPE_EVENT_HDR   = 4'd2;
    localparam logic [3:0] TYPE_TRIG_TIME   = 4'd3;
    localparam logic [3:0] TYPE_WINDOW_SUM  = 4'd5;
    localparam logic [3:0] TYPE_PULSE_INT   = 4'd7;
    localparam logic [3:0] TYPE_PULSE_TIME  = 4'd8;
    localparam logic [3:0] TYPE_PULSE_PED   = 4'd10;

    // filler words after a block trailer have bits 31..27 all ones
    localparam logic [4:0] FILLER_MARK = 5'h1F;

    // record kinds
    localparam logic [2:0] KIND_TRIG_TIME  = 3'd0;
    localparam logic [2:0] KIND_WINDOW_SUM = 3'd1;
    localparam logic [2:0] KIND_PULSE_INT  = 3'd2;
    localparam logic [2:0] KIND_PULSE_TIME = 3'd3;
    localparam logic [2:0] KIND_PULSE_PED  = 3'd4;

    // configuration register indexes
    localparam logic CFG_CRATE_ID       = 1'b0;
    localparam logic CFG_EVENTS_PER_BLK = 1'b1;

    localparam int  QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [4:0]  slot_number;
        logic [3:0]  channel_number;
        logic [21:0] trigger_number;
        logic [7:0]  event_slot_index;
        logic [1:0]  pulse_index;
        logic [1:0]  quality_bits;
        logic [47:0] main_value;
        logic [11:0] peak_value;
        logic        overflow_flag;
        logic        last_of_run;
    } record_t;

    typedef struct packed {
        logic [4:0]  current_slot;
        logic [21:0] current_trigger;
        logic [7:0]  event_counter;
        logic        event_active;
        logic        time_pending;
        logic [23:0] time_low_part;
        logic        trailer_seen;
    } dec_state_t;

    // records produced by one word, packed to the front
    typedef struct packed {
        logic [1:0] count;
        record_t    rec0;
        record_t    rec1;
    } dec_out_t;

endpackage

// ----- design/amwd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amwd_if
// item channels of the word decoder: readout words in, records out
// ----------------------------------------------------------------------------
interface amwd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        bank_end;

    modport source (output valid, output data_word, output bank_end, input ready);
    modport sink   (input valid, input data_word, input bank_end, output ready);
endinterface

interface amwd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  record_kind;
    logic [4:0]  slot_number;
    logic [3:0]  channel_number;
    logic [21:0] trigger_number;
    logic [7:0]  event_slot_index;
    logic [1:0]  pulse_index;
    logic [1:0]  quality_bits;
    logic [47:0] main_value;
    logic [11:0] peak_value;
    logic        overflow_flag;
    logic        last_of_run;

    modport source (
        output valid, output record_kind, output slot_number, output channel_number,
        output trigger_number, output event_slot_index, output pulse_index,
        output quality_bits, output main_value, output peak_value,
        output overflow_flag, output last_of_run, input ready
    );
    modport sink (
        input valid, input record_kind, input slot_number, input channel_number,
        input trigger_number, input event_slot_index, input pulse_index,
        input quality_bits, input main_value, input peak_value,
        input overflow_flag, input last_of_run, output ready
    );
endinterface

// ----- design/adc_module_word_decoder_top.sv -----
`timescale 1ns / 1ps
// path: an accepted word is held in the input register and decoded from there;
//   its records go into the result queue, whose head drives the record channel
// throughput: one word per cycle while the two-entry result queue has room for
//   all its records; records leave one per cycle while the record channel is ready
// reset: asynchronous active low, returns decoder state and config to reset values
//   and empties the result queue
// ----------------------------------------------------------------------------
// adc_module_word_decoder_top
// decodes flash-adc readout words into trigger time, sum and pulse records
// ----------------------------------------------------------------------------
module adc_module_word_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    amwd_in_if.sink     in_ch,
    amwd_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);
    import amwd_pkg::*;

    // configuration; the crate id is held for software and feeds no record
    logic [11:0] crate_id_reg;
    logic [7:0]  events_per_block_reg;

    // input register, parts the word channel from the decode
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] word_reg;
    logic        bank_end_reg;

    // block tracking state
    dec_state_t  st_reg;
    dec_state_t  st_next;

    dec_out_t    dec;
    logic [1:0]  room;
    logic        consume;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crate_id_reg         <= '0;
            events_per_block_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CRATE_ID:       crate_id_reg         <= cfg_data;
                CFG_EVENTS_PER_BLK: events_per_block_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    amwd_decode u_decode (
        .data_word        (word_reg),
        .bank_end         (bank_end_reg),
        .events_per_block (events_per_block_reg),
        .st               (st_reg),
        .st_next          (st_next),
        .dec              (dec)
    );

    // the held word moves on once the queue has room for all its records
    assign consume = in_valid_reg && (dec.count <= room);
    assign in_ch.ready = !in_valid_reg || consume;
    assign take = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_reg       <= '{current_slot:    '0,
                              current_trigger: '1,
                              event_counter:   '0,
                              event_active:    1'b0,
                              time_pending:    1'b0,
                              time_low_part:   '0,
                              trailer_seen:    1'b0};
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (consume)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg     <= in_ch.data_word;
            bank_end_reg <= in_ch.bank_end;
        end
    end

    // result queue drives the record channel straight from its head entry
    amwd_out_queue u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (consume),
        .dec    (dec),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

// ----- design/amwd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amwd_decode
// single-pass decode of one readout word into next state and up to two records
// ----------------------------------------------------------------------------
module amwd_decode (
    input  logic [31:0]          data_word,
    input  logic                 bank_end,
    input  logic [7:0]           events_per_block,
    input  amwd_pkg::dec_state_t st,
    output amwd_pkg::dec_state_t st_next,
    output amwd_pkg::dec_out_t   dec
);
    import amwd_pkg::*;

    function automatic dec_state_t start_block(input dec_state_t s);
        dec_state_t r;
        r                 = s;
        r.current_slot    = '0;
        r.current_trigger = '1;
        r.event_counter   = '0;
        r.event_active    = 1'b0;
        return r;
    endfunction

    record_t    rec_a;
    record_t    rec_b;
    logic       a_v;
    logic       b_v;
    logic       done;
    dec_state_t s;

    always_comb
    begin
        s     = st;
        done  = 1'b0;
        rec_a = '0;
        rec_b = '0;
        a_v   = 1'b0;
        b_v   = 1'b0;

        // pending trigger time: a continuation word supplies the high part
        if (st.time_pending)
        begin
            s.time_pending         = 1'b0;
            rec_a.record_kind      = KIND_TRIG_TIME;
            rec_a.slot_number      = st.current_slot;
            rec_a.trigger_number   = st.current_trigger;
            rec_a.event_slot_index = st.event_counter - 8'd1;
            rec_a.main_value       = {(data_word[31] ? 24'd0 : data_word[23:0]),
                                      st.time_low_part};
            a_v                    = st.event_active;
            done                   = ~data_word[31];
        end

        if (!done && st.trailer_seen)
        begin
            if (data_word[31:27] == FILLER_MARK)
            begin
                done = 1'b1;
            end
            else
            begin
                s              = start_block(s);
                s.trailer_seen = 1'b0;
            end
        end

        rec_b.slot_number      = s.current_slot;
        rec_b.trigger_number   = s.current_trigger;
        rec_b.event_slot_index = s.event_counter - 8'd1;
        rec_b.channel_number   = data_word[26:23];

        if (!done && data_word[31])
        begin
            case (data_word[30:27])
                TYPE_BLOCK_HDR:
                begin
                    s.current_slot = data_word[26:22];
                end
                TYPE_BLOCK_TRL:
                begin
                    s.trailer_seen = 1'b1;
                end
                TYPE_EVENT_HDR:
                begin
                    s.current_trigger = data_word[21:0];
                    if (s.event_counter < events_per_block)
                    begin
                        s.event_counter = s.event_counter + 8'd1;
                        s.event_active  = 1'b1;
                    end
                    else
                    begin
                        s.event_active = 1'b0;
                    end
                end
                TYPE_TRIG_TIME:
                begin
                    s.time_low_part = data_word[23:0];
                    s.time_pending  = 1'b1;
                    if (bank_end)
                    begin
                        // no word left to carry the high part
                        s.time_pending       = 1'b0;
                        rec_b.record_kind    = KIND_TRIG_TIME;
                        rec_b.channel_number = '0;
                        rec_b.main_value     = {24'd0, data_word[23:0]};
                        b_v                  = s.event_active;
                    end
                end
                TYPE_WINDOW_SUM:
                begin
                    rec_b.record_kind   = KIND_WINDOW_SUM;
                    rec_b.main_value    = {26'd0, data_word[21:0]};
                    rec_b.overflow_flag = data_word[22];
                    b_v                 = s.event_active;
                end
                TYPE_PULSE_INT:
                begin
                    rec_b.record_kind  = KIND_PULSE_INT;
                    rec_b.pulse_index  = data_word[22:21];
                    rec_b.quality_bits = data_word[20:19];
                    rec_b.main_value   = {29'd0, data_word[18:0]};
                    b_v                = s.event_active;
                end
                TYPE_PULSE_TIME:
                begin
                    rec_b.record_kind  = KIND_PULSE_TIME;
                    rec_b.pulse_index  = data_word[22:21];
                    rec_b.quality_bits = data_word[20:19];
                    rec_b.main_value   = {29'd0, data_word[18:0]};
                    b_v                = s.event_active;
                end
                TYPE_PULSE_PED:
                begin
                    rec_b.record_kind = KIND_PULSE_PED;
                    rec_b.pulse_index = data_word[22:21];
                    rec_b.main_value  = {39'd0, data_word[20:12]};
                    rec_b.peak_value  = data_word[11:0];
                    b_v               = s.event_active;
                end
                default:
                begin
                end
            endcase
        end

        if (bank_end)
        begin
            s              = start_block(s);
            s.time_pending = 1'b0;
            s.trailer_seen = 1'b0;
        end

        st_next = s;

        // pack to the front, mark the final record of the word
        dec = '0;
        if (a_v && b_v)
        begin
            dec.count            = 2'd2;
            dec.rec0             = rec_a;
            dec.rec1             = rec_b;
            dec.rec1.last_of_run = 1'b1;
        end
        else if (a_v || b_v)
        begin
            dec.count            = 2'd1;
            dec.rec0             = a_v ? rec_a : rec_b;
            dec.rec0.last_of_run = 1'b1;
        end
    end

endmodule

// ----- design/amwd_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amwd_out_queue
// two-entry result register queue feeding the record channel
// ----------------------------------------------------------------------------
module amwd_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  amwd_pkg::dec_out_t dec,
    output logic [1:0]         room,
    amwd_out_if.source         out_ch
);
    import amwd_pkg::*;

    record_t    q_reg [QUEUE_DEPTH];
    record_t    q_next [QUEUE_DEPTH];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;
    logic [1:0] base;
    logic [1:0] n_push;

    assign pop    = out_ch.valid && out_ch.ready;
    assign room   = 2'(QUEUE_DEPTH) - cnt_reg + {1'b0, pop};
    assign base   = cnt_reg - {1'b0, pop};
    assign n_push = push ? dec.count : 2'd0;

    always_comb
    begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        case (base)
            2'd0:
            begin
                q_next[0] = dec.rec0;
                q_next[1] = dec.rec1;
            end
            2'd1:
            begin
                q_next[1] = dec.rec0;
            end
            default:
            begin
            end
        endcase
        cnt_next = base + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign out_ch.valid            = (cnt_reg != 2'd0);
    assign out_ch.record_kind      = q_reg[0].record_kind;
    assign out_ch.slot_number      = q_reg[0].slot_number;
    assign out_ch.channel_number   = q_reg[0].channel_number;
    assign out_ch.trigger_number   = q_reg[0].trigger_number;
    assign out_ch.event_slot_index = q_reg[0].event_slot_index;
    assign out_ch.pulse_index      = q_reg[0].pulse_index;
    assign out_ch.quality_bits     = q_reg[0].quality_bits;
    assign out_ch.main_value       = q_reg[0].main_value;
    assign out_ch.peak_value       = q_reg[0].peak_value;
    assign out_ch.overflow_flag    = q_reg[0].overflow_flag;
    assign out_ch.last_of_run      = q_reg[0].last_of_run;

endmodule
